### hw/rtl/atmd_pkg.sv
package atmd_pkg;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned TexelW    = 32;
  localparam int unsigned AsumW     = 10;
  localparam int unsigned AccW      = 18;
  localparam int unsigned QuotW     = 8;
  localparam logic [AsumW-1:0] OpaqueSumMin = 10'd510;
  localparam logic [ChanW-1:0] AlphaOpaque  = 8'd255;

  typedef struct packed {
    logic [2:0][AccW-1:0] rem;
    logic [AsumW-1:0]     div;
    logic [2:0][QuotW-1:0] quo;
    logic                 opaque;
  } cell_data_t;
endpackage

### hw/rtl/alpha_tested_mip_downsample_unit.sv
// alpha-tested 2x2 mip downsample
// channels: pulse start with the four quad texels while busy is low; each
//   texel is rgba8 with red in bits 7:0 and alpha in 31:24
// busy is always low: one item is accepted every cycle
// results appear with out_valid high for one cycle, after start passes
//   through the prep register for the alpha sums and weighted sums, then a row
//   of eight restoring-division cells, one quotient bit per cell, msb first,
//   then the output register
// throughput: one item per cycle, fully pipelined
// out_alpha is 255 when the alpha bytes sum to at least 510, else 0, and
//   colour is zero for a transparent result
// reset clears the valid bits of every stage; items in flight are dropped
// the receiver cannot stall, so no backpressure exists in the pipeline
module alpha_tested_mip_downsample_unit
  import atmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [TexelW-1:0] in_texel_top_left,
  input  logic [TexelW-1:0] in_texel_top_right,
  input  logic [TexelW-1:0] in_texel_bottom_left,
  input  logic [TexelW-1:0] in_texel_bottom_right,
  output logic              out_valid,
  output logic [ChanW-1:0]  out_red,
  output logic [ChanW-1:0]  out_green,
  output logic [ChanW-1:0]  out_blue,
  output logic [ChanW-1:0]  out_alpha
);
  logic [QuotW:0] vld;
  cell_data_t     data [QuotW+1];
  logic           out_valid_r;
  logic [ChanW-1:0] red_r, green_r, blue_r, alpha_r;

  assign busy = 1'b0;

  atmd_prep u_prep (
    .clk(clk), .rst_n(rst_n), .vld_in(start),
    .texels({in_texel_bottom_right, in_texel_bottom_left,
             in_texel_top_right, in_texel_top_left}),
    .vld_r(vld[0]), .data_r(data[0])
  );

  for (genvar g = 0; g < QuotW; g++) begin : g_cell
    atmd_cell #(.Bit(QuotW - 1 - g)) u_cell (
      .clk(clk), .rst_n(rst_n), .vld_in(vld[g]), .data_in(data[g]),
      .vld_r(vld[g+1]), .data_r(data[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[QuotW];
    end
    red_r   <= data[QuotW].opaque ? data[QuotW].quo[0] : '0;
    green_r <= data[QuotW].opaque ? data[QuotW].quo[1] : '0;
    blue_r  <= data[QuotW].opaque ? data[QuotW].quo[2] : '0;
    alpha_r <= data[QuotW].opaque ? AlphaOpaque : '0;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha_r;
endmodule

### hw/rtl/atmd_prep.sv
module atmd_prep
  import atmd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_in,
  input  logic [3:0][TexelW-1:0]     texels,
  output logic                       vld_r,
  output cell_data_t                 data_r
);
  logic [AsumW-1:0] asum;
  logic [AsumW-1:0] wsum;
  logic [2:0][AccW-1:0] acc;
  logic [2:0][AccW-1:0] plain;
  cell_data_t data_nxt;
  logic vld_nxt;

  always_comb begin
    asum = '0;
    wsum = '0;
    acc = '0;
    plain = '0;
    for (int i = 0; i < 4; i++) begin
      asum = asum + AsumW'(texels[i][31:24]);
      for (int k = 0; k < 3; k++) begin
        plain[k] = plain[k] + AccW'(texels[i][8*k +: 8]);
      end
      if (texels[i][31]) begin
        wsum = wsum + AsumW'(texels[i][31:24]);
        for (int k = 0; k < 3; k++) begin
          acc[k] = acc[k] + AccW'({8'h00, texels[i][8*k +: 8]} * {8'h00, texels[i][31:24]});
        end
      end
    end
    data_nxt.opaque = (asum >= OpaqueSumMin);
    data_nxt.quo = '0;
    if (wsum != '0) begin
      data_nxt.rem = acc;
      data_nxt.div = wsum;
    end else begin
      data_nxt.rem = plain;
      data_nxt.div = AsumW'(4);
    end
    vld_nxt = vld_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    data_r <= data_nxt;
  end
endmodule

### hw/rtl/atmd_cell.sv
module atmd_cell
  import atmd_pkg::*;
#(
  parameter int unsigned Bit = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       vld_in,
  input  cell_data_t data_in,
  output logic       vld_r,
  output cell_data_t data_r
);
  cell_data_t data_nxt;
  logic [AccW-1:0] sh;

  always_comb begin
    data_nxt = data_in;
    sh = AccW'(data_in.div) << Bit;
    for (int k = 0; k < 3; k++) begin
      if (data_in.rem[k] >= sh && (data_in.div >> (AccW - Bit)) == '0) begin
        data_nxt.rem[k] = data_in.rem[k] - sh;
        data_nxt.quo[k][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    data_r <= data_nxt;
  end
endmodule

### hw/rtl/atmd_checker.sv
module atmd_checker
  import atmd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [ChanW-1:0] out_red,
  input logic [ChanW-1:0] out_alpha
);
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##10 out_valid)
    else $error("result missing");
  a_alpha_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == '0 || out_alpha == AlphaOpaque))
    else $error("alpha not binary");
  a_clear_colour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == '0) |-> out_red == '0)
    else $error("colour on transparent item");
endmodule

bind alpha_tested_mip_downsample_unit atmd_checker u_atmd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_red(out_red), .out_alpha(out_alpha)
);
